[rtl/core/ucd_pkg.sv]
// ----------------------------------------------------------------------------
// ucd_pkg - shared types and constants for the Unix time to calendar block
// Field widths, item structs, reciprocal constants for the divisions by
// constants, and the month tables of the March-based calendar.
// ----------------------------------------------------------------------------
package ucd_pkg;

    // Item field widths
    localparam int SECONDS_BITS = 40;
    localparam int MICROS_W     = 20;
    localparam int YEAR_W       = 16;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int HOURS_W      = 5;
    localparam int MINUTES_W    = 6;
    localparam int SECS_W       = 6;

    // Day count and second of the day
    localparam int DAYS_W        = 24;
    localparam int TOD_W         = 17;
    localparam int DAY_SHIFT     = 7;                      // 86400 = 128 * 675
    localparam int DAY_X_W       = SECONDS_BITS - DAY_SHIFT;
    localparam int DAY_DIV       = 675;
    localparam int DAY_RECIP_W   = 24;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
        DAY_RECIP_W'((64'd1 << DAY_X_W) / 64'd675);
    localparam int DAY_REM_W     = 11;

    // Gregorian century correction
    localparam int CENT_N_W      = 26;
    localparam int CENT_OFS      = 102032;
    localparam int CENT_DIV      = 146097;
    localparam int CENT_Q_W      = 9;
    localparam logic [CENT_Q_W-1:0] CENT_RECIP =
        CENT_Q_W'((64'd1 << CENT_N_W) / 64'd146097);
    localparam int CENT_REM_W    = 19;
    localparam int CENT_BIAS     = 15;

    // March-based year
    localparam int BASE_W        = 24;
    localparam int JD_OFS        = 2442113;
    localparam int YEAR_N_W      = 29;
    localparam int YEAR_OFS      = 2442;
    localparam int YEAR_DIV      = 7305;
    localparam int YR_W          = 16;
    localparam int YEAR_RECIP_W  = 17;
    localparam logic [YEAR_RECIP_W-1:0] YEAR_RECIP =
        YEAR_RECIP_W'((64'd1 << YEAR_N_W) / 64'd7305);
    localparam int YEAR_REM_W    = 14;
    localparam int DAYS_PER_YEAR = 365;

    // Month and day of month
    localparam int DOY_W         = 10;
    localparam int MON_W         = 5;
    localparam int MON_STEPS     = 16;
    localparam int MON_LAST_LATE = 13;
    localparam int MON_BIAS_LATE = 1;
    localparam int MON_BIAS_EARLY = 13;
    localparam int YEAR_BIAS_LATE = 4716;
    localparam int YEAR_BIAS_EARLY = 4715;

    // First day number of month k (k = 1..16): ceil(30.601 * k)
    localparam logic [DOY_W-1:0] MON_THRESH [0:MON_STEPS-1] = '{
        10'd31,  10'd62,  10'd92,  10'd123, 10'd154, 10'd184, 10'd215, 10'd245,
        10'd276, 10'd307, 10'd337, 10'd368, 10'd398, 10'd429, 10'd460, 10'd490
    };

    // Days before month k (k = 0..16): floor(30.601 * k)
    localparam logic [DOY_W-1:0] MON_FLOOR [0:MON_STEPS] = '{
        10'd0,   10'd30,  10'd61,  10'd91,  10'd122, 10'd153, 10'd183, 10'd214,
        10'd244, 10'd275, 10'd306, 10'd336, 10'd367, 10'd397, 10'd428, 10'd459,
        10'd489
    };

    // Time of day
    localparam int HOUR_SHIFT    = 4;                      // 3600 = 16 * 225
    localparam int HOUR_X_W      = TOD_W - HOUR_SHIFT;
    localparam int HOUR_DIV      = 225;
    localparam int HOUR_RECIP_W  = 6;
    localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP =
        HOUR_RECIP_W'((64'd1 << HOUR_X_W) / 64'd225);
    localparam int HOUR_REM_W    = 9;
    localparam int HOUR_SEC_W    = 12;
    localparam int MIN_SHIFT     = 2;                      // 60 = 4 * 15
    localparam int MIN_X_W       = HOUR_SEC_W - MIN_SHIFT;
    localparam int MIN_DIV       = 15;
    localparam int MIN_RECIP_W   = 7;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP =
        MIN_RECIP_W'((64'd1 << MIN_X_W) / 64'd15);
    localparam int MIN_REM_W     = 5;

    // Pipeline depth of the date path; the time path is padded to match
    localparam int DATE_STAGES   = 9;
    localparam int TOD_CORE      = 4;
    localparam int TOD_PAD       = DATE_STAGES - TOD_CORE;

    typedef struct packed {
        logic [SECONDS_BITS-1:0] epoch_seconds;
        logic [MICROS_W-1:0]     sub_micros;
    } ucd_in_t;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECS_W-1:0]    secs;
        logic [MICROS_W-1:0]  micros;
    } ucd_out_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } ucd_date_t;

    typedef struct packed {
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECS_W-1:0]    secs;
        logic [MICROS_W-1:0]  micros;
    } ucd_tod_t;

endpackage

[rtl/core/ucd_date.sv]
// ----------------------------------------------------------------------------
// ucd_date - day count to Gregorian year, month and day
// Nine-stage pipeline: century correction, March-based year by reciprocal
// multiply and correction, day of year, month search and fold-back.
// ----------------------------------------------------------------------------
module ucd_date (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  days_valid,
    input  logic [23:0]           days,
    output logic                  date_valid,
    output ucd_pkg::ucd_date_t    date
);
    import ucd_pkg::*;

    logic [DATE_STAGES-1:0] vld_reg;

    // Stage 1 signals and registers
    logic [CENT_N_W-1:0]            cent_n;
    logic [CENT_N_W+CENT_Q_W-1:0]   cent_prod;
    logic [DAYS_W-1:0]              d1_days_reg;
    logic [CENT_N_W-1:0]            d1_n_reg;
    logic [CENT_Q_W-1:0]            d1_q_reg;

    // Stage 2
    logic [CENT_N_W-1:0]            cent_back;
    logic [CENT_REM_W-1:0]          cent_rem;
    logic [CENT_Q_W-1:0]            cent_next;
    logic [DAYS_W-1:0]              d2_days_reg;
    logic [CENT_Q_W-1:0]            d2_cent_reg;

    // Stage 3
    logic [CENT_Q_W-1:0]            cent_b;
    logic [BASE_W-1:0]              base_next;
    logic [BASE_W-1:0]              d3_base_reg;

    // Stage 4
    logic [YEAR_N_W-1:0]            ny_next;
    logic [YEAR_N_W-1:0]            d4_ny_reg;
    logic [BASE_W-1:0]              d4_base_reg;

    // Stage 5
    logic [YEAR_N_W+YEAR_RECIP_W-1:0] year_prod;
    logic [YEAR_N_W-1:0]            d5_ny_reg;
    logic [YR_W-1:0]                d5_y_reg;
    logic [BASE_W-1:0]              d5_base_reg;

    // Stage 6
    logic [YEAR_N_W-1:0]            year_back;
    logic [YEAR_REM_W-1:0]          year_rem;
    logic [YR_W-1:0]                yr_next;
    logic [YR_W-1:0]                d6_yr_reg;
    logic [BASE_W-1:0]              d6_base_reg;

    // Stage 7
    logic [DOY_W-1:0]               doy_next;
    logic [DOY_W-1:0]               d7_doy_reg;
    logic [YR_W-1:0]                d7_yr_reg;

    // Stage 8
    logic [MON_STEPS-1:0]           mon_ge;
    logic [MON_W-1:0]               mon_next;
    logic [DOY_W-1:0]               d8_doy_reg;
    logic [MON_W-1:0]               d8_mon_reg;
    logic [YR_W-1:0]                d8_yr_reg;

    // Stage 9
    ucd_date_t                      date_next;
    ucd_date_t                      d9_date_reg;

    // Advance the valid bits with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DATE_STAGES-2:0], days_valid};
        end
    end

    // Estimate the century term: (4 * days + 102032) / 146097
    always_comb
    begin
        cent_n    = CENT_N_W'({days, 2'b00}) + CENT_N_W'(CENT_OFS);
        cent_prod = {{CENT_Q_W{1'b0}}, cent_n} * {{CENT_N_W{1'b0}}, CENT_RECIP};
    end

    // Correct the estimate by at most one
    always_comb
    begin
        cent_back = {{(CENT_N_W-CENT_Q_W){1'b0}}, d1_q_reg} * CENT_N_W'(CENT_DIV);
        cent_rem  = CENT_REM_W'(d1_n_reg - cent_back);
        cent_next = d1_q_reg + CENT_Q_W'(cent_rem >= CENT_REM_W'(CENT_DIV));
    end

    // Shift the day count to the Julian-style base
    always_comb
    begin
        cent_b    = d2_cent_reg + CENT_Q_W'(CENT_BIAS);
        base_next = d2_days_reg + BASE_W'(JD_OFS) + BASE_W'(cent_b)
                    - BASE_W'(cent_b >> 2);
    end

    // Scale for the year division: 20 * base - 2442
    always_comb
    begin
        ny_next = YEAR_N_W'({d3_base_reg, 4'b0000}) + YEAR_N_W'({d3_base_reg, 2'b00})
                  - YEAR_N_W'(YEAR_OFS);
    end

    // Estimate the year
    always_comb
    begin
        year_prod = {{YEAR_RECIP_W{1'b0}}, d4_ny_reg}
                    * {{YEAR_N_W{1'b0}}, YEAR_RECIP};
    end

    // Correct the year by at most one
    always_comb
    begin
        year_back = {{(YEAR_N_W-YR_W){1'b0}}, d5_y_reg} * YEAR_N_W'(YEAR_DIV);
        year_rem  = YEAR_REM_W'(d5_ny_reg - year_back);
        yr_next   = d5_y_reg + YR_W'(year_rem >= YEAR_REM_W'(YEAR_DIV));
    end

    // Day within the March-based year
    always_comb
    begin
        doy_next = DOY_W'(d6_base_reg - BASE_W'(d6_yr_reg) * BASE_W'(DAYS_PER_YEAR)
                          - BASE_W'(d6_yr_reg >> 2));
    end

    // Count the month boundaries already passed
    always_comb
    begin
        for (int k = 0; k < MON_STEPS; k++)
        begin
            mon_ge[k] = (d7_doy_reg >= MON_THRESH[k]);
        end
        mon_next = MON_W'($countones(mon_ge));
    end

    // Day of month, then fold January and February into the next year
    always_comb
    begin
        date_next.day = DAY_W'(d8_doy_reg - MON_FLOOR[d8_mon_reg]);
        if (d8_mon_reg <= MON_W'(MON_LAST_LATE))
        begin
            date_next.year  = YEAR_W'(d8_yr_reg - YR_W'(YEAR_BIAS_LATE));
            date_next.month = MONTH_W'(d8_mon_reg - MON_W'(MON_BIAS_LATE));
        end
        else
        begin
            date_next.year  = YEAR_W'(d8_yr_reg - YR_W'(YEAR_BIAS_EARLY));
            date_next.month = MONTH_W'(d8_mon_reg - MON_W'(MON_BIAS_EARLY));
        end
    end

    // Load each stage when its item arrives
    always_ff @(posedge clk)
    begin
        if (days_valid)
        begin
            d1_days_reg <= days;
            d1_n_reg    <= cent_n;
            d1_q_reg    <= cent_prod[CENT_N_W +: CENT_Q_W];
        end
        if (vld_reg[0])
        begin
            d2_days_reg <= d1_days_reg;
            d2_cent_reg <= cent_next;
        end
        if (vld_reg[1])
        begin
            d3_base_reg <= base_next;
        end
        if (vld_reg[2])
        begin
            d4_ny_reg   <= ny_next;
            d4_base_reg <= d3_base_reg;
        end
        if (vld_reg[3])
        begin
            d5_ny_reg   <= d4_ny_reg;
            d5_y_reg    <= year_prod[YEAR_N_W +: YR_W];
            d5_base_reg <= d4_base_reg;
        end
        if (vld_reg[4])
        begin
            d6_yr_reg   <= yr_next;
            d6_base_reg <= d5_base_reg;
        end
        if (vld_reg[5])
        begin
            d7_doy_reg  <= doy_next;
            d7_yr_reg   <= d6_yr_reg;
        end
        if (vld_reg[6])
        begin
            d8_doy_reg  <= d7_doy_reg;
            d8_mon_reg  <= mon_next;
            d8_yr_reg   <= d7_yr_reg;
        end
        if (vld_reg[7])
        begin
            d9_date_reg <= date_next;
        end
    end

    assign date_valid = vld_reg[DATE_STAGES-1];
    assign date       = d9_date_reg;

endmodule

[rtl/core/ucd_tod.sv]
// ----------------------------------------------------------------------------
// ucd_tod - second of the day to hours, minutes and seconds
// Four stages of reciprocal estimate and correction, then a delay line that
// keeps the time fields in step with the date path.
// ----------------------------------------------------------------------------
module ucd_tod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tod_valid,
    input  logic [16:0]         tod,
    input  logic [19:0]         micros,
    output ucd_pkg::ucd_tod_t   hms
);
    import ucd_pkg::*;

    logic [DATE_STAGES-1:0] vld_reg;

    // Stage 1
    logic [HOUR_X_W-1:0]               hour_x;
    logic [HOUR_X_W+HOUR_RECIP_W-1:0]  hour_prod;
    logic [HOUR_X_W-1:0]               t1_x_reg;
    logic [HOURS_W-1:0]                t1_h_reg;
    logic [HOUR_SHIFT-1:0]             t1_lo_reg;
    logic [MICROS_W-1:0]               t1_us_reg;

    // Stage 2
    logic [HOUR_X_W-1:0]               hour_back;
    logic [HOUR_REM_W-1:0]             hour_rem;
    logic [HOURS_W-1:0]                hours_next;
    logic [HOUR_REM_W-1:0]             hour_rem_fix;
    logic [HOURS_W-1:0]                t2_h_reg;
    logic [HOUR_SEC_W-1:0]             t2_rem_reg;
    logic [MICROS_W-1:0]               t2_us_reg;

    // Stage 3
    logic [MIN_X_W-1:0]                min_x;
    logic [MIN_X_W+MIN_RECIP_W-1:0]    min_prod;
    logic [HOURS_W-1:0]                t3_h_reg;
    logic [MIN_X_W-1:0]                t3_x_reg;
    logic [MINUTES_W-1:0]              t3_m_reg;
    logic [MIN_SHIFT-1:0]              t3_lo_reg;
    logic [MICROS_W-1:0]               t3_us_reg;

    // Stage 4
    logic [MIN_X_W-1:0]                min_back;
    logic [MIN_REM_W-1:0]              min_rem;
    ucd_tod_t                          hms_next;
    ucd_tod_t                          t4_hms_reg;

    // Padding to the date path depth
    ucd_tod_t                          pad_reg [0:TOD_PAD-1];

    // Advance the valid bits with the items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DATE_STAGES-2:0], tod_valid};
        end
    end

    // Estimate hours from the second of the day in units of 16 s
    always_comb
    begin
        hour_x    = tod[TOD_W-1:HOUR_SHIFT];
        hour_prod = {{HOUR_RECIP_W{1'b0}}, hour_x} * {{HOUR_X_W{1'b0}}, HOUR_RECIP};
    end

    // Correct hours by at most one and form the second of the hour
    always_comb
    begin
        hour_back = {{(HOUR_X_W-HOURS_W){1'b0}}, t1_h_reg} * HOUR_X_W'(HOUR_DIV);
        hour_rem  = HOUR_REM_W'(t1_x_reg - hour_back);
        if (hour_rem >= HOUR_REM_W'(HOUR_DIV))
        begin
            hours_next   = t1_h_reg + HOURS_W'(1);
            hour_rem_fix = hour_rem - HOUR_REM_W'(HOUR_DIV);
        end
        else
        begin
            hours_next   = t1_h_reg;
            hour_rem_fix = hour_rem;
        end
    end

    // Estimate minutes from the second of the hour in units of 4 s
    always_comb
    begin
        min_x    = t2_rem_reg[HOUR_SEC_W-1:MIN_SHIFT];
        min_prod = {{MIN_RECIP_W{1'b0}}, min_x} * {{MIN_X_W{1'b0}}, MIN_RECIP};
    end

    // Correct minutes by at most one and form the second of the minute
    always_comb
    begin
        min_back        = {{(MIN_X_W-MINUTES_W){1'b0}}, t3_m_reg} * MIN_X_W'(MIN_DIV);
        min_rem         = MIN_REM_W'(t3_x_reg - min_back);
        hms_next.hours  = t3_h_reg;
        hms_next.micros = t3_us_reg;
        if (min_rem >= MIN_REM_W'(MIN_DIV))
        begin
            hms_next.minutes = t3_m_reg + MINUTES_W'(1);
            hms_next.secs    = SECS_W'({4'(min_rem - MIN_REM_W'(MIN_DIV)), t3_lo_reg});
        end
        else
        begin
            hms_next.minutes = t3_m_reg;
            hms_next.secs    = SECS_W'({4'(min_rem), t3_lo_reg});
        end
    end

    // Load each stage when its item arrives
    always_ff @(posedge clk)
    begin
        if (tod_valid)
        begin
            t1_x_reg  <= hour_x;
            t1_h_reg  <= hour_prod[HOUR_X_W +: HOURS_W];
            t1_lo_reg <= tod[HOUR_SHIFT-1:0];
            t1_us_reg <= micros;
        end
        if (vld_reg[0])
        begin
            t2_h_reg   <= hours_next;
            t2_rem_reg <= {hour_rem_fix[HOUR_SEC_W-HOUR_SHIFT-1:0], t1_lo_reg};
            t2_us_reg  <= t1_us_reg;
        end
        if (vld_reg[1])
        begin
            t3_h_reg  <= t2_h_reg;
            t3_x_reg  <= min_x;
            t3_m_reg  <= min_prod[MIN_X_W +: MINUTES_W];
            t3_lo_reg <= t2_rem_reg[MIN_SHIFT-1:0];
            t3_us_reg <= t2_us_reg;
        end
        if (vld_reg[2])
        begin
            t4_hms_reg <= hms_next;
        end
        if (vld_reg[TOD_CORE-1])
        begin
            pad_reg[0] <= t4_hms_reg;
        end
        for (int i = 1; i < TOD_PAD; i++)
        begin
            if (vld_reg[TOD_CORE-1+i])
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
        end
    end

    assign hms = pad_reg[TOD_PAD-1];

endmodule

[rtl/core/unix_time_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// unix_time_to_calendar_date - Unix timestamp to Gregorian date and time
// Splits seconds since 1970 into a day count and a second of the day, then
// converts both in parallel pipelines.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on stamp and raise start; it is taken at that clock edge.
//   busy is held low, so an item may be taken at every edge and the block
//   sustains one item per cycle.
//   Each item gives one result. done is high for exactly one cycle with the
//   result on result. The depth is set by the eleven register stages of the
//   date path: day split (2), century term (2), base (1), year estimate and
//   correction (3), day of year (1), month (1), day of month and fold-back
//   (1). The time of day path is padded to match.
//   Results leave in the order the items came in. The receiver cannot hold
//   results off; every result is shown once and then replaced.
//   Reset clears all valid bits: items in flight are dropped and no done
//   pulse follows until new items are taken.
// ----------------------------------------------------------------------------
module unix_time_to_calendar_date (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ucd_pkg::ucd_in_t   stamp,
    output logic               done,
    output ucd_pkg::ucd_out_t  result
);
    import ucd_pkg::*;

    logic                           accept;

    // Stage 1: day count estimate
    logic [DAY_X_W-1:0]             day_x;
    logic [DAY_X_W+DAY_RECIP_W-1:0] day_prod;
    logic                           s1_valid_reg;
    logic [DAY_X_W-1:0]             s1_x_reg;
    logic [DAYS_W-1:0]              s1_q_reg;
    logic [DAY_SHIFT-1:0]           s1_lo_reg;
    logic [MICROS_W-1:0]            s1_us_reg;

    // Stage 2: corrected day count and second of the day
    logic [DAY_X_W-1:0]             day_back;
    logic [DAY_REM_W-1:0]           day_rem;
    logic [DAYS_W-1:0]              days_next;
    logic [DAY_REM_W-1:0]           day_rem_fix;
    logic                           s2_valid_reg;
    logic [DAYS_W-1:0]              s2_days_reg;
    logic [TOD_W-1:0]               s2_tod_reg;
    logic [MICROS_W-1:0]            s2_us_reg;

    logic                           date_valid;
    ucd_date_t                      date;
    ucd_tod_t                       hms;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Estimate the day count: (seconds / 128) / 675
    always_comb
    begin
        day_x    = stamp.epoch_seconds[SECONDS_BITS-1:DAY_SHIFT];
        day_prod = {{DAY_RECIP_W{1'b0}}, day_x} * {{DAY_X_W{1'b0}}, DAY_RECIP};
    end

    // Correct the day count by at most one
    always_comb
    begin
        day_back = {{(DAY_X_W-DAYS_W){1'b0}}, s1_q_reg} * DAY_X_W'(DAY_DIV);
        day_rem  = DAY_REM_W'(s1_x_reg - day_back);
        if (day_rem >= DAY_REM_W'(DAY_DIV))
        begin
            days_next   = s1_q_reg + DAYS_W'(1);
            day_rem_fix = day_rem - DAY_REM_W'(DAY_DIV);
        end
        else
        begin
            days_next   = s1_q_reg;
            day_rem_fix = day_rem;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Load the front stages when an item arrives
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg  <= day_x;
            s1_q_reg  <= day_prod[DAY_X_W +: DAYS_W];
            s1_lo_reg <= stamp.epoch_seconds[DAY_SHIFT-1:0];
            s1_us_reg <= stamp.sub_micros;
        end
        if (s1_valid_reg)
        begin
            s2_days_reg <= days_next;
            s2_tod_reg  <= {day_rem_fix[TOD_W-DAY_SHIFT-1:0], s1_lo_reg};
            s2_us_reg   <= s1_us_reg;
        end
    end

    ucd_date u_date (
        .clk        (clk),
        .rst_n      (rst_n),
        .days_valid (s2_valid_reg),
        .days       (s2_days_reg),
        .date_valid (date_valid),
        .date       (date)
    );

    ucd_tod u_tod (
        .clk        (clk),
        .rst_n      (rst_n),
        .tod_valid  (s2_valid_reg),
        .tod        (s2_tod_reg),
        .micros     (s2_us_reg),
        .hms        (hms)
    );

    // Merge the two paths into the result item
    assign done           = date_valid;
    assign result.year    = date.year;
    assign result.month   = date.month;
    assign result.day     = date.day;
    assign result.hours   = hms.hours;
    assign result.minutes = hms.minutes;
    assign result.secs    = hms.secs;
    assign result.micros  = hms.micros;

endmodule
